/* rtl/fpr_pkg.sv */
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared widths, constants and types of the framed packet receiver.
// ----------------------------------------------------------------------------
package fpr_pkg;

  // largest payload a frame may carry
  localparam int MAX_PAYLOAD = 64;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = $clog2(MAX_PAYLOAD);
  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);

  // payload store holds two frames, one per bank
  localparam int RAM_DEPTH = 2 * MAX_PAYLOAD;
  localparam int ADDR_W    = IDX_W + 1;

  // start marker after reset
  localparam logic [BYTE_W-1:0] START_RESET = 8'hAA;

  // result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1) + 1;

  // checked frame handed from parser to emitter
  typedef struct packed {
    logic [BYTE_W-1:0] id;
    logic [LEN_W-1:0]  len;
    logic              bank;
  } desc_t;

  // one result request
  typedef struct packed {
    logic [BYTE_W-1:0] id;
    logic [LEN_W-1:0]  len;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
    logic              last;
  } result_t;

endpackage

/* rtl/framed_packet_receiver.sv */
// ----------------------------------------------------------------------------
// framed_packet_receiver
// Serial frame deframer with XOR check, parser and emitter decoupled.
// ----------------------------------------------------------------------------
// Usage:
//   Input is a queue of received bytes: a byte is taken on a clock edge with
//   push high and full low. Frames are marker, id, length, payload, check.
//   Results form a queue: while empty is low the oldest result is on
//   frame_id, payload_len, byte_index, payload_byte and last_of_frame, and
//   pop with empty low takes it. One result per payload byte, one empty
//   result for a zero length frame; bad frames give nothing.
//   start_marker is written through cfg_valid / cfg_ready / cfg_data;
//   cfg_ready is always high. The user must write it only while the block is idle; the block does not enforce this.
// Timing:
//   One byte per cycle is taken while full is low. The first result of a good
//   frame passes the descriptor queue, the store read and the aligned stage;
//   results then follow at one per cycle while pop keeps up (single read port).
//   The store has two banks, so full rises only while two good frames are
//   still waiting to be emitted, e.g. when the receiver stops popping.
// Reset:
//   rst clears the parser to the hunt, the marker to 0xAA and both queues.
// ----------------------------------------------------------------------------
module framed_packet_receiver import fpr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BYTE_W-1:0] cfg_data,
  // byte input
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] rx_byte,
  // results
  input  logic              pop,
  output logic              empty,
  output logic [BYTE_W-1:0] frame_id,
  output logic [LEN_W-1:0]  payload_len,
  output logic [IDX_W-1:0]  byte_index,
  output logic [BYTE_W-1:0] payload_byte,
  output logic              last_of_frame
);

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              desc_push;
  desc_t             desc;
  logic              frame_done;
  result_t           head;

  // parser
  fpr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .rx_byte    (rx_byte),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .desc_push  (desc_push),
    .desc       (desc),
    .frame_done (frame_done)
  );

  // payload store, two banks
  fpr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // emitter
  fpr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_push  (desc_push),
    .desc       (desc),
    .frame_done (frame_done),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .pop        (pop),
    .empty      (empty),
    .head       (head)
  );

  // result fields
  assign frame_id      = head.id;
  assign payload_len   = head.len;
  assign byte_index    = head.idx;
  assign payload_byte  = head.data;
  assign last_of_frame = head.last;

endmodule

/* rtl/fpr_ram.sv */
// ----------------------------------------------------------------------------
// fpr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/fpr_front.sv */
// ----------------------------------------------------------------------------
// fpr_front
// Byte parser: hunts for the marker, stores payload, checks the XOR byte
// and hands each good frame to the emitter as a descriptor.
// ----------------------------------------------------------------------------
module fpr_front import fpr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BYTE_W-1:0] cfg_data,
  // byte input
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] rx_byte,
  // payload store write side
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [BYTE_W-1:0] ram_wdata,
  // to emitter
  output logic              desc_push,
  output desc_t             desc,
  input  logic              frame_done
);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_ID    = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;

  logic [2:0]        phase;
  logic [BYTE_W-1:0] start_marker;
  logic [BYTE_W-1:0] held_id;
  logic [LEN_W-1:0]  held_len;
  logic [LEN_W-1:0]  byte_count;
  logic [BYTE_W-1:0] running_check;
  logic              wr_bank;
  logic [1:0]        frames_held;
  logic              accept;
  logic [LEN_W-1:0]  count_inc;

  // both banks hold frames waiting for the emitter
  assign full      = (frames_held == 2'd2);
  assign accept    = push && !full;
  assign cfg_ready = 1'b1;
  assign count_inc = byte_count + LEN_W'(1);

  // payload store write
  assign ram_we    = accept && (phase == PH_DATA);
  assign ram_waddr = {wr_bank, byte_count[IDX_W-1:0]};
  assign ram_wdata = rx_byte;

  // good check byte releases the frame
  assign desc_push = accept && (phase == PH_CHECK) && (rx_byte == running_check);
  assign desc.id   = held_id;
  assign desc.len  = held_len;
  assign desc.bank = wr_bank;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      start_marker  <= START_RESET;
      held_id       <= '0;
      held_len      <= '0;
      byte_count    <= '0;
      running_check <= '0;
      wr_bank       <= 1'b0;
      frames_held   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        start_marker <= cfg_data;
      end

      // banks in use
      if (desc_push && !frame_done) begin
        frames_held <= frames_held + 2'd1;
      end else if (!desc_push && frame_done) begin
        frames_held <= frames_held - 2'd1;
      end

      if (desc_push) begin
        wr_bank <= ~wr_bank;
      end

      if (accept) begin
        case (phase)
          PH_ID: begin
            held_id       <= rx_byte;
            running_check <= rx_byte;
            phase         <= PH_LEN;
          end
          PH_LEN: begin
            if (rx_byte > BYTE_W'(MAX_PAYLOAD)) begin
              phase         <= PH_HUNT;
              held_id       <= '0;
              held_len      <= '0;
              byte_count    <= '0;
              running_check <= '0;
            end else begin
              held_len      <= rx_byte[LEN_W-1:0];
              byte_count    <= '0;
              running_check <= running_check ^ rx_byte;
              phase         <= (rx_byte == '0) ? PH_CHECK : PH_DATA;
            end
          end
          PH_DATA: begin
            running_check <= running_check ^ rx_byte;
            byte_count    <= count_inc;
            if (count_inc >= held_len) begin
              phase <= PH_CHECK;
            end
          end
          PH_CHECK: begin
            phase         <= PH_HUNT;
            held_id       <= '0;
            held_len      <= '0;
            byte_count    <= '0;
            running_check <= '0;
          end
          default: begin
            phase <= (rx_byte == start_marker) ? PH_ID : PH_HUNT;
          end
        endcase
      end
    end
  end

  // never more frames than banks
  a_frames_bound: assert property (@(posedge clk) disable iff (rst)
    frames_held != 2'd3)
    else $error("fpr_front: bank count overflow");

  // a frame is only released while a bank is free
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    desc_push |-> frames_held != 2'd2)
    else $error("fpr_front: frame released with both banks busy");

endmodule

/* rtl/fpr_back.sv */
// ----------------------------------------------------------------------------
// fpr_back
// Frame emitter: takes checked frames from a two-entry queue, reads their
// payload from the store and fills the result queue.
// ----------------------------------------------------------------------------
module fpr_back import fpr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // from parser
  input  logic              desc_push,
  input  desc_t             desc,
  output logic              frame_done,
  // payload store read side
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [BYTE_W-1:0] ram_rdata,
  // result queue
  input  logic              pop,
  output logic              empty,
  output result_t           head
);

  desc_t                desc_q [2];
  logic                 dq_wr;
  logic                 dq_rd;
  logic [1:0]           dq_cnt;
  logic                 dq_pop;

  logic                 active;
  desc_t                cur;
  logic [IDX_W-1:0]     idx;
  logic                 credit;
  logic                 issue;
  logic                 is_zero;
  logic                 is_last;

  logic                 s1_valid;
  logic                 s1_zero;
  result_t              s1_res;

  result_t              out_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] oq_wr;
  logic [OUT_PTR_W-1:0] oq_rd;
  logic [OUT_CNT_W-1:0] out_cnt;
  logic                 oq_pop;

  // descriptor queue
  assign dq_pop = !active && (dq_cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (desc_push) begin
      desc_q[dq_wr] <= desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dq_wr  <= 1'b0;
      dq_rd  <= 1'b0;
      dq_cnt <= '0;
    end else begin
      if (desc_push) begin
        dq_wr <= ~dq_wr;
      end
      if (dq_pop) begin
        dq_rd <= ~dq_rd;
      end
      if (desc_push && !dq_pop) begin
        dq_cnt <= dq_cnt + 2'd1;
      end else if (!desc_push && dq_pop) begin
        dq_cnt <= dq_cnt - 2'd1;
      end
    end
  end

  // read issue, only with room for the result in the queue
  assign credit     = (out_cnt + OUT_CNT_W'(s1_valid)) < OUT_CNT_W'(OUT_DEPTH);
  assign issue      = active && credit;
  assign is_zero    = (cur.len == '0);
  assign is_last    = is_zero || ({1'b0, idx} == (cur.len - LEN_W'(1)));
  assign frame_done = issue && is_last;
  assign ram_re     = issue;
  assign ram_raddr  = {cur.bank, idx};

  // frame walker
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (dq_pop) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (issue) begin
      if (is_last) begin
        active <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dq_pop) begin
      cur <= desc_q[dq_rd];
    end
  end

  // stage aligned with the store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_zero     <= is_zero;
      s1_res.id   <= cur.id;
      s1_res.len  <= cur.len;
      s1_res.idx  <= idx;
      // empty result carries a zero byte
      s1_res.data <= '0;
      s1_res.last <= is_last;
    end
  end

  // result queue
  assign oq_pop = pop && (out_cnt != '0);
  assign empty  = (out_cnt == '0);
  assign head   = out_q[oq_rd];

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      out_q[oq_wr] <= '{id:   s1_res.id,
                        len:  s1_res.len,
                        idx:  s1_res.idx,
                        data: s1_zero ? s1_res.data : ram_rdata,
                        last: s1_res.last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr   <= '0;
      oq_rd   <= '0;
      out_cnt <= '0;
    end else begin
      if (s1_valid) begin
        oq_wr <= oq_wr + OUT_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + OUT_PTR_W'(1);
      end
      if (s1_valid && !oq_pop) begin
        out_cnt <= out_cnt + OUT_CNT_W'(1);
      end else if (!s1_valid && oq_pop) begin
        out_cnt <= out_cnt - OUT_CNT_W'(1);
      end
    end
  end

  // descriptor queue never overruns
  a_dq_overrun: assert property (@(posedge clk) disable iff (rst)
    desc_push |-> (dq_cnt != 2'd2) || dq_pop)
    else $error("fpr_back: descriptor queue overrun");

  // a read in flight always finds room in the result queue
  a_oq_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> out_cnt < OUT_CNT_W'(OUT_DEPTH) || oq_pop)
    else $error("fpr_back: result queue overrun");

  // each store read lands in the aligned stage next cycle
  a_read_stage: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> s1_valid)
    else $error("fpr_back: read result lost");

endmodule
